[design/cda_pkg.sv]
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types and constants for the calendar date arithmetic unit.
// ----------------------------------------------------------------------------
package cda_pkg;

  // day numbers count from 0000-01-01; 26 bits cover every year up to 2^17-1
  localparam int DN_W   = 26;
  localparam int YFLD_W = 14;
  localparam int CNT_W  = 22;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_DIFF = 2'd2,
    OP_CMP  = 2'd3
  } cda_op_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [YFLD_W-1:0] a_year;
    logic [3:0]        a_month;
    logic [4:0]        a_day;
    logic [YFLD_W-1:0] b_year;
    logic [3:0]        b_month;
    logic [4:0]        b_day;
    logic [CNT_W-1:0]  day_offset;
  } cda_req_t;

  typedef struct packed {
    logic [YFLD_W-1:0] res_year;
    logic [3:0]        res_month;
    logic [4:0]        res_day;
    logic [CNT_W-1:0]  day_count;
    logic              a_greater;
    logic              dates_equal;
    logic              a_less;
    logic              out_of_range;
  } cda_rsp_t;

  // year unit result: days before the year and its leap flag
  typedef struct packed {
    logic [DN_W-1:0] dby;
    logic            leap;
  } cda_yinfo_t;

endpackage

[design/calendar_date_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_unit
// Gregorian date add, subtract, day difference and compare on day numbers.
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid_i / req_ready_o / req_i carry two dates, an
//   operation and a day offset; a request is taken when valid and ready meet
//   response channel: rsp_valid_o / rsp_ready_i / rsp_o carry one result
//   per request, held in an output register until the receiver takes it
//   both dates are clamped (year to MAX_YEAR, month to 1..12, day to the
//   month length) and turned into day numbers from 0000-01-01
//   one shared year unit (a reciprocal multiply for /100 plus adders) is
//   reused by a small sequencer: it evaluates each date in turn, then, for
//   add and subtract, runs a bitwise year search that presents and checks
//   one candidate per year bit and walks the months; difference and
//   compare skip the search and the walk; one request is worked at a time;
//   req_ready_o is high only when idle, but a finished result waiting on a
//   stalled receiver does not block the next request: the sequencer only
//   waits when it must load a new result
//   reset clears the sequencer and drops rsp_valid_o; no memory to clear
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_unit
  import cda_pkg::*;
#(
  parameter int MAX_YEAR    = 9999,
  parameter int OFFSET_BITS = 22
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  cda_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output cda_rsp_t rsp_o
);

  // year width covers MAX_YEAR + 1, the bound used by the year search
  localparam int YW     = $clog2(MAX_YEAR + 2);
  localparam int BW     = (YW > 1) ? $clog2(YW) : 1;
  localparam int Y1     = MAX_YEAR + 1;
  localparam int NMAX_I = 365 * Y1 + (Y1 + 3) / 4 - (Y1 + 99) / 100 + (Y1 + 399) / 400 - 1;
  localparam logic [DN_W-1:0]  NMAX     = DN_W'(NMAX_I);
  localparam logic [CNT_W-1:0] OFF_MASK = (OFFSET_BITS >= CNT_W) ? {CNT_W{1'b1}} :
                                          CNT_W'((64'd1 << OFFSET_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_A, S_B, S_NA, S_NB, S_OP, S_SAT, S_CNT,
    S_YI, S_YC, S_YL, S_M0, S_MS, S_DONE
  } state_e;

  // month length in days
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the months before m, non-leap year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // zero-based day of year, day clamped to 1..month length
  function automatic logic [8:0] day_of_year(input logic [3:0] m, input logic [4:0] d,
                                             input logic leap);
    logic [4:0] len;
    logic [4:0] dc;
    len = month_len(m, leap);
    dc  = (d == 5'd0) ? 5'd1 : ((d > len) ? len : d);
    return cum_days(m) + 9'((m > 4'd2) && leap) + 9'(dc) - 9'd1;
  endfunction

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    return (m == 4'd0) ? 4'd1 : ((m > 4'd12) ? 4'd12 : m);
  endfunction

  function automatic logic [YW-1:0] clamp_year(input logic [YFLD_W-1:0] y);
    return (32'(y) > 32'(MAX_YEAR)) ? YW'(MAX_YEAR) : YW'(y);
  endfunction

  state_e             state_q;
  logic [1:0]         op_q;
  logic [YW-1:0]      ay_q, by_q;
  logic [3:0]         am_q, bm_q;
  logic [4:0]         ad_q, bd_q;
  logic [CNT_W-1:0]   off_q;
  logic [DN_W-1:0]    dbya_q, dbyb_q;
  logic [8:0]         doya_q, doyb_q;
  logic [DN_W-1:0]    na_q, nb_q;
  logic [DN_W:0]      sum_q;
  logic [DN_W-1:0]    n_q;
  logic [YW-1:0]      yy_q;
  logic [BW-1:0]      bit_q;
  logic [DN_W-1:0]    dsel_q;
  logic               leap_q;
  logic [8:0]         doy_q;
  logic [3:0]         mm_q;
  cda_rsp_t           res_q;
  cda_rsp_t           rsp_q;
  logic               rsp_valid_q;

  logic [YW-1:0]      cand;
  logic [YW-1:0]      yr_in;
  cda_yinfo_t         yinfo;
  logic [4:0]         mlen;
  logic               rsp_load;

  // shared year evaluator, result valid in the cycle after the year is presented
  cda_year_unit #(
    .YEAR_W (YW)
  ) u_year (
    .clk_i  (clk_i),
    .year_i (yr_in),
    .info_o (yinfo)
  );

  assign cand = yy_q | (YW'(1) << bit_q);
  assign mlen = month_len(mm_q, leap_q);

  // output register is free or being emptied this cycle
  assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready_i);

  always_comb begin
    case (state_q)
      S_A:     yr_in = ay_q;
      S_B:     yr_in = by_q;
      S_YI:    yr_in = cand;
      default: yr_in = yy_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            op_q  <= req_i.operation;
            ay_q  <= clamp_year(req_i.a_year);
            by_q  <= clamp_year(req_i.b_year);
            am_q  <= clamp_month(req_i.a_month);
            bm_q  <= clamp_month(req_i.b_month);
            ad_q  <= req_i.a_day;
            bd_q  <= req_i.b_day;
            off_q <= req_i.day_offset & OFF_MASK;
            res_q <= '0;
            state_q <= S_A;
          end
        end
        S_A: begin
          state_q <= S_B;
        end
        // year unit now holds date a
        S_B: begin
          dbya_q  <= yinfo.dby;
          doya_q  <= day_of_year(am_q, ad_q, yinfo.leap);
          state_q <= S_NA;
        end
        // year unit now holds date b
        S_NA: begin
          dbyb_q  <= yinfo.dby;
          doyb_q  <= day_of_year(bm_q, bd_q, yinfo.leap);
          na_q    <= dbya_q + DN_W'(doya_q);
          state_q <= S_NB;
        end
        S_NB: begin
          nb_q    <= dbyb_q + DN_W'(doyb_q);
          state_q <= S_OP;
        end
        S_OP: begin
          res_q.a_greater   <= na_q > nb_q;
          res_q.dates_equal <= na_q == nb_q;
          res_q.a_less      <= na_q < nb_q;
          case (op_q)
            OP_ADD:  sum_q <= {1'b0, na_q} + (DN_W+1)'(off_q);
            OP_SUB:  sum_q <= {1'b0, na_q} - (DN_W+1)'(off_q);
            default: sum_q <= {1'b0, na_q} - {1'b0, nb_q};
          endcase
          state_q <= S_SAT;
        end
        S_SAT: begin
          yy_q   <= '0;
          bit_q  <= BW'(YW - 1);
          dsel_q <= '0;
          case (op_q)
            OP_ADD: begin
              if (sum_q[DN_W-1:0] > NMAX) begin
                n_q <= NMAX;
                res_q.out_of_range <= 1'b1;
              end else begin
                n_q <= sum_q[DN_W-1:0];
              end
              state_q <= S_YI;
            end
            OP_SUB: begin
              if (sum_q[DN_W]) begin
                n_q <= '0;
                res_q.out_of_range <= 1'b1;
              end else begin
                n_q <= sum_q[DN_W-1:0];
              end
              state_q <= S_YI;
            end
            OP_DIFF: begin
              n_q     <= sum_q[DN_W] ? (~sum_q[DN_W-1:0] + DN_W'(1)) : sum_q[DN_W-1:0];
              state_q <= S_CNT;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_CNT: begin
          if (n_q > DN_W'(OFF_MASK)) begin
            res_q.day_count    <= OFF_MASK;
            res_q.out_of_range <= 1'b1;
          end else begin
            res_q.day_count <= CNT_W'(n_q);
          end
          state_q <= S_DONE;
        end
        // bitwise search for the largest year starting on or before n
        S_YI: begin
          state_q <= S_YC;
        end
        S_YC: begin
          if (yinfo.dby <= n_q) begin
            yy_q   <= cand;
            dsel_q <= yinfo.dby;
          end
          if (bit_q == '0) begin
            state_q <= S_YL;
          end else begin
            bit_q   <= bit_q - BW'(1);
            state_q <= S_YI;
          end
        end
        S_YL: begin
          state_q <= S_M0;
        end
        S_M0: begin
          leap_q  <= yinfo.leap;
          doy_q   <= 9'(n_q - dsel_q);
          mm_q    <= 4'd1;
          state_q <= S_MS;
        end
        // one month per cycle
        S_MS: begin
          if ((doy_q < 9'(mlen)) || (mm_q == 4'd12)) begin
            res_q.res_year  <= YFLD_W'(yy_q);
            res_q.res_month <= mm_q;
            res_q.res_day   <= 5'(doy_q + 9'd1);
            state_q         <= S_DONE;
          end else begin
            doy_q <= doy_q - 9'(mlen);
            mm_q  <= mm_q + 4'd1;
          end
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  // a new result only appears out of the load state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_o) |-> $past(state_q == S_DONE))
    else $error("response raised outside load state");

  // exactly one ordering relation holds between the two dates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $onehot({rsp_o.a_greater, rsp_o.dates_equal, rsp_o.a_less}))
    else $error("compare flags not one-hot");

  // a date result is either absent or a real calendar date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> ((rsp_o.res_month == 4'd0 && rsp_o.res_day == 5'd0) ||
                     (rsp_o.res_month != 4'd0 && rsp_o.res_month <= 4'd12 &&
                      rsp_o.res_day != 5'd0)))
    else $error("malformed result date");

  // month walk never leaves the year
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MS) |-> (mm_q != 4'd0 && mm_q <= 4'd12 && doy_q < 9'd366))
    else $error("month walk out of range");
`endif

endmodule

[design/cda_year_unit.sv]
// ----------------------------------------------------------------------------
// cda_year_unit
// Shared year evaluator: days in all years before a given year, and leap flag.
// ----------------------------------------------------------------------------
module cda_year_unit
  import cda_pkg::*;
#(
  parameter int YEAR_W = 14
) (
  input  logic              clk_i,
  input  logic [YEAR_W-1:0] year_i,
  output cda_yinfo_t        info_o
);

  // floor(y / 100) as (y * RECIP) >> 24, exact for y below 199728
  localparam int RECIP_100 = 167773;
  localparam int RECIP_SH  = 24;
  localparam int PW        = YEAR_W + 20;
  localparam int QW        = YEAR_W - 4;

  logic [PW-1:0]       prod;
  logic [YEAR_W:0]     yp3;
  logic [DN_W-1:0]     base_d;
  logic [YEAR_W-1:0]   y_q;
  logic [QW-1:0]       q_q;
  logic [DN_W-1:0]     base_q;
  logic [YEAR_W-1:0]   hund;
  logic [6:0]          rem;
  logic [QW:0]         c100;
  logic [QW+1:0]       c400;

  assign prod   = PW'(year_i) * PW'(RECIP_100);
  assign yp3    = {1'b0, year_i} + (YEAR_W+1)'(3);
  assign base_d = DN_W'(year_i) * DN_W'(365) + DN_W'(yp3 >> 2);

  always_ff @(posedge clk_i) begin
    y_q    <= year_i;
    q_q    <= prod[RECIP_SH +: QW];
    base_q <= base_d;
  end

  // remainder mod 100 gives ceil(y/100); ceil(y/400) = ceil(ceil(y/100)/4)
  assign hund = YEAR_W'(q_q) * YEAR_W'(100);
  assign rem  = 7'(y_q - hund);
  assign c100 = (QW+1)'(q_q) + (QW+1)'(rem != 7'd0);
  assign c400 = ({1'b0, c100} + (QW+2)'(3)) >> 2;

  assign info_o.dby  = base_q - DN_W'(c100) + DN_W'(c400);
  assign info_o.leap = (y_q[1:0] == 2'b00) && ((rem != 7'd0) || (q_q[1:0] == 2'b00));

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the calendar date arithmetic unit: a directed set of
// calendar corner cases followed by random date requests, all predicted by a
// Gregorian day-number model and checked field by field against each response.
// ----------------------------------------------------------------------------
module tb_top;
  import cda_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_YEAR     = 9999;
  localparam int OFFSET_BITS  = 22;
  localparam int RANDOM_REQS  = 1600;
  localparam int WATCHDOG     = 3000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 60;    // a bit over the longest add latency
  localparam int CHOKE_AT     = 400;   // responses seen before the long stall
  localparam int CHOKE_CYCLES = 300;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_ready;
  cda_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  cda_rsp_t rsp;

  // requests waiting for the driver, results waiting for the dut
  cda_req_t date_requests[$];
  cda_rsp_t due_results[$];

  logic req_taken = 1'b0;
  logic rsp_taken = 1'b0;
  int   mismatches = 0;
  int   reqs_sent = 0;
  int   rsps_seen = 0;
  int   quiet_cycles = 0;

  calendar_date_arithmetic_unit #(
    .MAX_YEAR   (MAX_YEAR),
    .OFFSET_BITS(OFFSET_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // gregorian day-number model
  // --------------------------------------------------------------------------

  // divisible by 4, but centuries only when divisible by 400; year 0 is leap
  function automatic bit is_leap_year(int y);
    return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
  endfunction

  function automatic int month_days(int y, int m);
    case (m)
      2:              return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // days in all years before y
  function automatic int days_to_year(int y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic int day_number(int y, int m, int d);
    int n;
    n = days_to_year(y);
    for (int k = 1; k < m; k++) n += month_days(y, k);
    return n + d - 1;
  endfunction

  function automatic void date_of_number(int n, output int y, output int m,
                                         output int d);
    longint est;
    est = (longint'(n) * 400) / 146097;
    y = int'(est);
    // the 400-year estimate can be off by one either way
    while (y > 0 && days_to_year(y) > n) y--;
    while (days_to_year(y + 1) <= n) y++;
    n -= days_to_year(y);
    m = 1;
    while (m < 12 && n >= month_days(y, m)) begin
      n -= month_days(y, m);
      m++;
    end
    d = n + 1;
  endfunction

  // same clamping as the unit: year, then month, then day in that month
  function automatic void clamp_date(inout int y, inout int m, inout int d);
    if (y > MAX_YEAR) y = MAX_YEAR;
    if (m == 0) m = 1;
    if (m > 12) m = 12;
    if (d == 0) d = 1;
    if (d > month_days(y, m)) d = month_days(y, m);
  endfunction

  function automatic cda_rsp_t predict_date_result(cda_req_t r);
    int ay, am, ad, by, bm, bd;
    int na, nb, n, last_day, ry, rm, rd;
    longint off, span, span_max;
    cda_rsp_t o;
    o  = '0;
    ay = int'(r.a_year);  am = int'(r.a_month);  ad = int'(r.a_day);
    by = int'(r.b_year);  bm = int'(r.b_month);  bd = int'(r.b_day);
    clamp_date(ay, am, ad);
    clamp_date(by, bm, bd);
    na       = day_number(ay, am, ad);
    nb       = day_number(by, bm, bd);
    last_day = day_number(MAX_YEAR, 12, 31);
    off      = longint'(r.day_offset) & ((longint'(1) << OFFSET_BITS) - 1);
    span_max = (longint'(1) << OFFSET_BITS) - 1;
    if (span_max > (longint'(1) << CNT_W) - 1) span_max = (longint'(1) << CNT_W) - 1;

    case (cda_op_e'(r.operation))
      OP_ADD, OP_SUB: begin
        if (cda_op_e'(r.operation) == OP_ADD) begin
          // saturate at the last day of MAX_YEAR
          if (na + off > last_day) begin
            n = last_day;
            o.out_of_range = 1'b1;
          end else begin
            n = int'(na + off);
          end
        end else begin
          // saturate at 0000-01-01
          if (off > na) begin
            n = 0;
            o.out_of_range = 1'b1;
          end else begin
            n = int'(na - off);
          end
        end
        date_of_number(n, ry, rm, rd);
        o.res_year  = YFLD_W'(ry);
        o.res_month = 4'(rm);
        o.res_day   = 5'(rd);
      end
      OP_DIFF: begin
        span = longint'((na > nb) ? na - nb : nb - na);
        if (span > span_max) begin
          span = span_max;
          o.out_of_range = 1'b1;
        end
        o.day_count = CNT_W'(span);
      end
      default: ;
    endcase
    // ordering flags come out for every operation
    o.a_greater   = na > nb;
    o.dates_equal = na == nb;
    o.a_less      = na < nb;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------

  task automatic report_error(string msg);
    $display("[%0t] error: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report_error($sformatf("response %0d %s got %0d, want %0d", rsps_seen, name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // request generation
  // --------------------------------------------------------------------------

  function automatic cda_req_t make_req(cda_op_e op, int ay, int am, int ad,
                                        int by, int bm, int bd, int off);
    cda_req_t r;
    r.operation  = op;
    r.a_year     = YFLD_W'(ay);
    r.a_month    = 4'(am);
    r.a_day      = 5'(ad);
    r.b_year     = YFLD_W'(by);
    r.b_month    = 4'(bm);
    r.b_day      = 5'(bd);
    r.day_offset = CNT_W'(off);
    return r;
  endfunction

  // mostly legal years, some at the ends, some past MAX_YEAR up to all ones
  function automatic int pick_year();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 3);
      1:       return $urandom_range(MAX_YEAR - 3, MAX_YEAR);
      2:       return $urandom_range(0, (1 << YFLD_W) - 1);
      default: return $urandom_range(0, MAX_YEAR);
    endcase
  endfunction

  function automatic int pick_month();
    return ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
  endfunction

  function automatic int pick_day();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 28);
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 400);
      1:       return $urandom_range(0, 40000);
      2:       return $urandom_range(0, 1000000);
      default: return $urandom & ((1 << CNT_W) - 1);
    endcase
  endfunction

  initial begin
    // leap rules, month ends and year wrap
    date_requests.push_back(make_req(OP_ADD, 2024, 2, 28, 2024, 3, 1, 1));
    date_requests.push_back(make_req(OP_ADD, 1900, 2, 28, 1900, 3, 1, 1));
    date_requests.push_back(make_req(OP_ADD, 2000, 2, 28, 2000, 2, 29, 1));
    date_requests.push_back(make_req(OP_ADD, 2100, 2, 28, 2100, 3, 1, 1));
    date_requests.push_back(make_req(OP_SUB, 2001, 1, 1, 2000, 12, 31, 1));
    date_requests.push_back(make_req(OP_ADD, 0, 2, 29, 0, 1, 1, 0));
    // saturation at both ends of the calendar
    date_requests.push_back(make_req(OP_ADD, MAX_YEAR, 12, 31, 0, 1, 1, 1));
    date_requests.push_back(make_req(OP_ADD, 0, 1, 1, MAX_YEAR, 12, 31, (1 << CNT_W) - 1));
    date_requests.push_back(make_req(OP_SUB, 0, 1, 1, 0, 1, 1, 1));
    date_requests.push_back(make_req(OP_SUB, MAX_YEAR, 12, 31, 0, 1, 1,
                                     day_number(MAX_YEAR, 12, 31)));
    date_requests.push_back(make_req(OP_SUB, 5000, 6, 15, 5000, 6, 15, (1 << CNT_W) - 1));
    date_requests.push_back(make_req(OP_ADD, 1234, 5, 6, 1234, 5, 6, 0));
    date_requests.push_back(make_req(OP_SUB, 1234, 5, 6, 1234, 5, 6, 0));
    // differences, widest span, zero span, B after A, short month
    date_requests.push_back(make_req(OP_DIFF, 0, 1, 1, MAX_YEAR, 12, 31, 0));
    date_requests.push_back(make_req(OP_DIFF, 1999, 7, 4, 1999, 7, 4, 0));
    date_requests.push_back(make_req(OP_DIFF, 2023, 4, 31, 2023, 5, 1, 0));
    date_requests.push_back(make_req(OP_DIFF, MAX_YEAR, 12, 31, 0, 1, 1, 77));
    // compare: equal, later, earlier, and equal only after clamping
    date_requests.push_back(make_req(OP_CMP, 1600, 2, 29, 1600, 2, 29, 0));
    date_requests.push_back(make_req(OP_CMP, 2000, 1, 2, 2000, 1, 1, 0));
    date_requests.push_back(make_req(OP_CMP, 2000, 1, 1, 2000, 1, 2, 0));
    date_requests.push_back(make_req(OP_CMP, (1 << YFLD_W) - 1, 15, 31, MAX_YEAR, 12, 31, 0));
    // clamping of out-of-range fields
    date_requests.push_back(make_req(OP_ADD, (1 << YFLD_W) - 1, 15, 31, 0, 0, 0, 0));
    date_requests.push_back(make_req(OP_ADD, 2023, 0, 0, 2023, 1, 1, 0));
    date_requests.push_back(make_req(OP_ADD, 2023, 2, 31, 2024, 2, 31, 0));
    date_requests.push_back(make_req(OP_CMP, 2023, 2, 31, 2023, 3, 0, 0));

    for (int i = 0; i < RANDOM_REQS; i++)
      date_requests.push_back(make_req(cda_op_e'($urandom_range(0, 3)),
                                       pick_year(), pick_month(), pick_day(),
                                       pick_year(), pick_month(), pick_day(),
                                       pick_offset()));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // everything sent, everything answered, then let the pipe settle
    while (date_requests.size() != 0 || req_valid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (due_results.size() != 0)
      report_error($sformatf("%0d results never arrived", due_results.size()));

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // request driver
  // --------------------------------------------------------------------------

  // gap_left counts idle cycles after the current request is taken
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!req_valid || req_taken)) begin
      if (gap_left > 0) begin
        req_valid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (date_requests.size() != 0) begin
        req_valid <= 1'b1;
        req       <= date_requests.pop_front();
        reqs_sent <= reqs_sent + 1;
        // every fourth stretch of requests runs back to back
        gap_left  <= ((reqs_sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 5);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // response receiver
  // --------------------------------------------------------------------------

  int  stall_left = 0;
  int  choke_left = 0;
  bit  choke_done = 1'b0;

  always @(negedge clk_i) begin : rx_side
    int pause;
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else if (choke_left > 0) begin
      rsp_ready  <= 1'b0;
      choke_left <= choke_left - 1;
    end else if (!choke_done && rsps_seen == CHOKE_AT) begin
      // long hold-off so the unit fills up and pushes back on requests
      choke_done <= 1'b1;
      choke_left <= CHOKE_CYCLES - 1;
      rsp_ready  <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rsp_taken) begin
      pause = ((rsps_seen / 110) % 4 == 1) ? 0 : $urandom_range(0, 5);
      if (pause == 0) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready  <= 1'b0;
        stall_left <= pause - 1;
      end
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predicts on request, checks on response, watches for hangs
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    cda_rsp_t want;
    req_taken <= rst_ni && req_valid && req_ready;
    rsp_taken <= rst_ni && rsp_valid && rsp_ready;
    if (rst_ni) begin
      if (req_valid && req_ready) due_results.push_back(predict_date_result(req));

      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          report_error("response with no request outstanding");
        end else begin
          want = due_results.pop_front();
          check_field("res_year",     32'(rsp.res_year),     32'(want.res_year));
          check_field("res_month",    32'(rsp.res_month),    32'(want.res_month));
          check_field("res_day",      32'(rsp.res_day),      32'(want.res_day));
          check_field("day_count",    32'(rsp.day_count),    32'(want.day_count));
          check_field("a_greater",    32'(rsp.a_greater),    32'(want.a_greater));
          check_field("dates_equal",  32'(rsp.dates_equal),  32'(want.dates_equal));
          check_field("a_less",       32'(rsp.a_less),       32'(want.a_less));
          check_field("out_of_range", 32'(rsp.out_of_range), 32'(want.out_of_range));
        end
        rsps_seen <= rsps_seen + 1;
      end

      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG) begin
        $display("timeout: no request or response for %0d cycles", WATCHDOG);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
